// ----- rtl/core/ams_pkg.sv -----
// Package for the accumulator machine step block
// Holds item and result structs, opcodes, codes, controller state and command types
// No dependencies
package ams_pkg;

  // input item and result item
  typedef struct packed {
    logic [1:0]         opcode;
    logic [11:0]        address;
    logic signed [31:0] data_word;
    logic               mark_instruction;
    logic signed [31:0] input_value;
  } ams_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         output_kind;
    logic signed [31:0] output_value;
    logic               used_input;
    logic signed [31:0] pc_now;
    logic signed [31:0] acc_now;
    logic [2:0]         flags_now;
  } ams_out_t;

  // item kinds
  localparam logic [1:0] ITEM_EXEC  = 2'd0;
  localparam logic [1:0] ITEM_LOAD  = 2'd1;
  localparam logic [1:0] ITEM_REGS  = 2'd2;
  localparam logic [1:0] ITEM_CLEAR = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_HALT    = 3'd1;
  localparam logic [2:0] STAT_INVALID = 3'd2;
  localparam logic [2:0] STAT_ABORT   = 3'd3;
  localparam logic [2:0] STAT_BREAK   = 3'd4;
  localparam logic [2:0] STAT_ESCAPE  = 3'd5;

  // console output kinds
  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_INT  = 2'd1;
  localparam logic [1:0] OUT_CHAR = 2'd2;

  // instruction set
  localparam logic [5:0] OP_LOAD     = 6'd0;
  localparam logic [5:0] OP_STORE    = 6'd1;
  localparam logic [5:0] OP_CLEAR    = 6'd2;
  localparam logic [5:0] OP_ADD      = 6'd3;
  localparam logic [5:0] OP_INC      = 6'd4;
  localparam logic [5:0] OP_SUB      = 6'd5;
  localparam logic [5:0] OP_DEC      = 6'd6;
  localparam logic [5:0] OP_CMP      = 6'd7;
  localparam logic [5:0] OP_JMP      = 6'd8;
  localparam logic [5:0] OP_JGT      = 6'd9;
  localparam logic [5:0] OP_JEQ      = 6'd10;
  localparam logic [5:0] OP_JLT      = 6'd11;
  localparam logic [5:0] OP_JNE      = 6'd12;
  localparam logic [5:0] OP_READINT  = 6'd13;
  localparam logic [5:0] OP_WRITEINT = 6'd14;
  localparam logic [5:0] OP_HALT     = 6'd15;
  localparam logic [5:0] OP_LOADX    = 6'd16;
  localparam logic [5:0] OP_STOREX   = 6'd17;
  localparam logic [5:0] OP_LOADIX   = 6'd18;
  localparam logic [5:0] OP_STOREIX  = 6'd19;
  localparam logic [5:0] OP_READCH   = 6'd20;
  localparam logic [5:0] OP_WRITECH  = 6'd21;
  localparam logic [5:0] OP_CALL     = 6'd22;
  localparam logic [5:0] OP_RET      = 6'd23;
  localparam logic [5:0] OP_PUSH     = 6'd24;
  localparam logic [5:0] OP_POP      = 6'd25;
  localparam logic [5:0] OP_JMPI     = 6'd26;
  localparam logic [5:0] OP_JGTI     = 6'd27;
  localparam logic [5:0] OP_JEQI     = 6'd28;
  localparam logic [5:0] OP_JLTI     = 6'd29;
  localparam logic [5:0] OP_JNEI     = 6'd30;
  localparam logic [5:0] OP_LOADV    = 6'd31;
  localparam logic [5:0] OP_MUL      = 6'd32;
  localparam logic [5:0] OP_DIV      = 6'd33;
  localparam logic [5:0] OP_MOD      = 6'd34;
  localparam logic [5:0] OP_NOT      = 6'd35;
  localparam logic [5:0] OP_AND      = 6'd36;
  localparam logic [5:0] OP_OR       = 6'd37;
  localparam logic [5:0] OP_CALLI    = 6'd38;

  localparam int OPCODE_COUNT = 39;
  localparam int ADDR_BITS    = 11;
  localparam int FILL_VALUE   = (OPCODE_COUNT + 1) * 2048;
  localparam int STACK_RESET  = 2000;
  localparam int LOADV_LIMIT  = 1023;
  localparam logic [31:0] PC_RESET = 32'd10;
  localparam int CODE_LF  = 10;
  localparam int CODE_CR  = 13;
  localparam int CODE_ESC = 27;

  // multiply and divide modes
  typedef enum logic [1:0] {
    MD_MUL,
    MD_DIV,
    MD_REM
  } ams_md_e;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MISC,
    ST_FETCH,
    ST_DECODE,
    ST_PRE,
    ST_WR_CHK,
    ST_WR_DO,
    ST_RD,
    ST_RD_WAIT,
    ST_MD_GO,
    ST_MD,
    ST_EXEC
  } ams_state_e;

  // which phases an instruction needs
  typedef struct packed {
    logic pre;
    logic rd;
    logic wr;
    logic wr_first;
    logic md;
  } ams_opinfo_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic misc;
    logic clr_step;
    logic fetch;
    logic decode;
    logic pre;
    logic wr_chk;
    logic wr_do;
    logic rd;
    logic rd_wait;
    logic md_start;
    logic exec;
  } ams_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0]  item_kind;
    logic        op_valid;
    ams_opinfo_t info;
    logic        md_done;
    logic        clr_last;
    logic        out_free;
  } ams_stat_t;

  function automatic ams_opinfo_t ams_op_info(input logic [5:0] op);
    ams_opinfo_t r;
    r = '0;
    case (op)
      OP_LOAD, OP_ADD, OP_SUB, OP_CMP, OP_WRITEINT, OP_HALT, OP_LOADX, OP_LOADIX,
      OP_RET, OP_JMPI, OP_JGTI, OP_JEQI, OP_JLTI, OP_JNEI, OP_AND, OP_OR: begin
        r.rd = 1'b1;
      end
      OP_INC, OP_DEC, OP_POP: begin
        r.rd = 1'b1;
        r.wr = 1'b1;
      end
      OP_STORE, OP_READINT, OP_STOREX, OP_STOREIX: begin
        r.wr = 1'b1;
      end
      OP_CALL: begin
        r.pre = 1'b1;
        r.wr  = 1'b1;
      end
      OP_PUSH: begin
        r.pre = 1'b1;
        r.rd  = 1'b1;
        r.wr  = 1'b1;
      end
      OP_CALLI: begin
        r.pre      = 1'b1;
        r.rd       = 1'b1;
        r.wr       = 1'b1;
        r.wr_first = 1'b1;
      end
      OP_MUL, OP_DIV, OP_MOD: begin
        r.rd = 1'b1;
        r.md = 1'b1;
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/ams_muldiv.sv -----
// Shared iterative multiplier and divider, one bit per cycle
// Depends on ams_pkg for the mode type
module ams_muldiv #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  ams_pkg::ams_md_e     mode_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] result_o
);

  localparam int CB = $clog2(WORD_BITS);

  logic                 busy_q, done_q, neg_q;
  logic [CB-1:0]        cnt_q;
  ams_pkg::ams_md_e     mode_q;
  logic [WORD_BITS-1:0] lo_q, hi_q, mc_q;
  logic [WORD_BITS:0]   trial;
  logic                 fits;

  // one restoring step on the partial remainder
  assign trial = {hi_q, lo_q[WORD_BITS-1]} - {1'b0, mc_q};
  assign fits  = !trial[WORD_BITS];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CB'(WORD_BITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
      cnt_q <= cnt_q + CB'(1);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      if (mode_i == ams_pkg::MD_MUL) begin
        lo_q  <= '0;
        hi_q  <= b_i;
        mc_q  <= a_i;
        neg_q <= 1'b0;
      end else begin
        lo_q  <= a_i[WORD_BITS-1] ? -a_i : a_i;
        hi_q  <= '0;
        mc_q  <= b_i[WORD_BITS-1] ? -b_i : b_i;
        neg_q <= (mode_i == ams_pkg::MD_REM) ? a_i[WORD_BITS-1]
                                             : (a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1]);
      end
    end else if (busy_q) begin
      if (mode_q == ams_pkg::MD_MUL) begin
        if (hi_q[0]) begin
          lo_q <= lo_q + mc_q;
        end
        mc_q <= {mc_q[WORD_BITS-2:0], 1'b0};
        hi_q <= {1'b0, hi_q[WORD_BITS-1:1]};
      end else begin
        hi_q <= fits ? trial[WORD_BITS-1:0] : {hi_q[WORD_BITS-2:0], lo_q[WORD_BITS-1]};
        lo_q <= {lo_q[WORD_BITS-2:0], fits};
      end
    end
  end

  // result with sign fix-up
  always_comb begin
    case (mode_q)
      ams_pkg::MD_MUL: result_o = lo_q;
      ams_pkg::MD_DIV: result_o = neg_q ? -lo_q : lo_q;
      ams_pkg::MD_REM: result_o = neg_q ? -hi_q : hi_q;
      default:         result_o = lo_q;
    endcase
  end

  assign done_o = done_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("muldiv did not start");

endmodule

// ----- rtl/core/ams_dp.sv -----
// Datapath of the accumulator machine: word memory, registers, address and result logic
// Depends on ams_pkg and ams_muldiv
module ams_dp #(
  parameter int MEMORY_WORDS = 4096,
  parameter int WORD_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ams_pkg::ams_cmd_t   cmd_i,
  output ams_pkg::ams_stat_t  stat_o,
  input  ams_pkg::ams_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ams_pkg::ams_out_t   out_data_o,
  input  logic                cfg_valid_i,
  input  logic [11:0]         cfg_data_i
);

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam int CW = (WORD_BITS > 32) ? WORD_BITS : 32;
  localparam logic [WORD_BITS-1:0] FillWord = WORD_BITS'(ams_pkg::FILL_VALUE);
  localparam logic [WORD_BITS-1:0] SpReset  = WORD_BITS'(ams_pkg::STACK_RESET);

  // word memory, top bit is the instruction mark
  logic [WORD_BITS:0] mem_q [MEMORY_WORDS];
  logic [WORD_BITS:0] mem_rdata_q;

  logic [WORD_BITS-1:0] acc_q, x_q, sp_q, instr_q, opnd_q;
  logic [2:0]           mark_q, flags_q;
  logic [31:0]          pc_q;
  logic [11:0]          bp_q;
  logic                 abort_q, out_valid_q;
  ams_pkg::ams_in_t     item_q;
  ams_pkg::ams_out_t    out_q;
  logic [AW-1:0]        clr_cnt_q;
  logic                 rd_oor_q, rd_hit_q;
  logic [1:0]           rd_idx_q;

  logic [WORD_BITS-1:0] rd_val, instr_now, idx_sum, in_w, ld_word, wr_data, md_res;
  logic                 rd_mark, op_valid, wr_ok, md_done, clr_last, out_free;
  logic [5:0]           op;
  logic [10:0]          adr;
  logic [CW-1:0]        pc_ext, adr_ext, idx_ext, sp_ext, src_addr, dst_addr, rd_addr;
  logic                 rd_in, rd_hit, load_in, load_reg;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [WORD_BITS:0]   mem_wd;
  ams_pkg::ams_md_e     md_mode;

  // result of the execute commit
  logic [WORD_BITS-1:0] acc_n, x_n, sp_n, cmp_b, rc_val;
  logic [31:0]          pc_n;
  logic                 fl_set, div_zero;
  logic [2:0]           flags_n;
  ams_pkg::ams_out_t    res;

  // current instruction and its fields
  assign instr_now = cmd_i.decode ? rd_val : instr_q;
  assign op        = 6'(instr_now >> ams_pkg::ADDR_BITS);
  assign op_valid  = (instr_now >> ams_pkg::ADDR_BITS) < WORD_BITS'(ams_pkg::OPCODE_COUNT);
  assign adr       = instr_now[ams_pkg::ADDR_BITS-1:0];

  // address sources
  assign idx_sum = WORD_BITS'(adr) + x_q;
  assign pc_ext  = CW'($signed(pc_q));
  assign adr_ext = CW'(adr);
  assign idx_ext = CW'($signed(idx_sum));
  assign sp_ext  = CW'($signed(sp_q));

  always_comb begin
    case (op)
      ams_pkg::OP_LOADIX:                 src_addr = idx_ext;
      ams_pkg::OP_RET, ams_pkg::OP_POP:   src_addr = sp_ext;
      default:                            src_addr = adr_ext;
    endcase
    case (op)
      ams_pkg::OP_STOREIX:                dst_addr = idx_ext;
      ams_pkg::OP_CALL, ams_pkg::OP_PUSH,
      ams_pkg::OP_CALLI:                  dst_addr = sp_ext;
      default:                            dst_addr = adr_ext;
    endcase
  end

  assign rd_addr = cmd_i.fetch ? pc_ext : (cmd_i.wr_chk ? dst_addr : src_addr);
  assign rd_in   = !rd_addr[CW-1] && (rd_addr < CW'(MEMORY_WORDS));
  assign rd_hit  = rd_in && (rd_addr < CW'(3));

  // read data, words 0 to 2 live in registers
  always_comb begin
    rd_val  = mem_rdata_q[WORD_BITS-1:0];
    rd_mark = mem_rdata_q[WORD_BITS];
    if (rd_hit_q) begin
      case (rd_idx_q)
        2'd0:    rd_val = acc_q;
        2'd1:    rd_val = x_q;
        default: rd_val = sp_q;
      endcase
      case (rd_idx_q)
        2'd0:    rd_mark = mark_q[0];
        2'd1:    rd_mark = mark_q[1];
        default: rd_mark = mark_q[2];
      endcase
    end
    if (rd_oor_q) begin
      rd_val  = '0;
      rd_mark = 1'b0;
    end
  end

  // store data and checks
  assign in_w    = WORD_BITS'($signed(item_q.input_value));
  assign ld_word = WORD_BITS'($signed(item_q.data_word));
  assign wr_ok   = !rd_oor_q && !rd_mark;
  assign load_in = 32'(item_q.address) < 32'(MEMORY_WORDS);
  assign load_reg = item_q.address < 12'd3;

  always_comb begin
    case (op)
      ams_pkg::OP_INC:                     wr_data = opnd_q + WORD_BITS'(1);
      ams_pkg::OP_DEC:                     wr_data = opnd_q - WORD_BITS'(1);
      ams_pkg::OP_READINT:                 wr_data = in_w;
      ams_pkg::OP_STOREX:                  wr_data = x_q;
      ams_pkg::OP_CALL, ams_pkg::OP_CALLI: wr_data = WORD_BITS'($signed(pc_q));
      ams_pkg::OP_PUSH, ams_pkg::OP_POP:   wr_data = opnd_q;
      default:                             wr_data = acc_q;
    endcase
  end

  // memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt_q;
    mem_wd = {1'b0, FillWord};
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.misc && item_q.opcode == ams_pkg::ITEM_LOAD && load_in && !load_reg) begin
      mem_we = 1'b1;
      mem_wa = AW'(item_q.address);
      mem_wd = {item_q.mark_instruction, ld_word};
    end else if (cmd_i.wr_do && wr_ok && !rd_hit_q) begin
      mem_we = 1'b1;
      mem_wa = dst_addr[AW-1:0];
      mem_wd = {1'b0, wr_data};
    end
  end

  // memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    mem_rdata_q <= mem_q[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    rd_oor_q <= !rd_in;
    rd_hit_q <= rd_hit;
    rd_idx_q <= rd_addr[1:0];
  end

  // multiply and divide unit
  always_comb begin
    case (op)
      ams_pkg::OP_DIV: md_mode = ams_pkg::MD_DIV;
      ams_pkg::OP_MOD: md_mode = ams_pkg::MD_REM;
      default:         md_mode = ams_pkg::MD_MUL;
    endcase
  end

  ams_muldiv #(
    .WORD_BITS (WORD_BITS)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.md_start),
    .mode_i   (md_mode),
    .a_i      (acc_q),
    .b_i      (opnd_q),
    .done_o   (md_done),
    .result_o (md_res)
  );

  // instruction effects at commit
  assign rc_val   = (in_w == WORD_BITS'(ams_pkg::CODE_LF)) ? WORD_BITS'(ams_pkg::CODE_CR) : in_w;
  assign div_zero = (op == ams_pkg::OP_DIV || op == ams_pkg::OP_MOD) && opnd_q == '0;

  always_comb begin
    acc_n  = acc_q;
    x_n    = x_q;
    sp_n   = sp_q;
    pc_n   = pc_q;
    fl_set = 1'b0;
    cmp_b  = '0;
    if (item_q.opcode == ams_pkg::ITEM_EXEC && op_valid) begin
      case (op)
        ams_pkg::OP_LOAD, ams_pkg::OP_LOADIX: begin
          acc_n  = opnd_q;
          fl_set = 1'b1;
        end
        ams_pkg::OP_CLEAR: begin
          acc_n  = '0;
          fl_set = 1'b1;
        end
        ams_pkg::OP_ADD: begin
          acc_n  = acc_q + opnd_q;
          fl_set = 1'b1;
        end
        ams_pkg::OP_SUB: begin
          acc_n  = acc_q - opnd_q;
          fl_set = 1'b1;
        end
        ams_pkg::OP_STORE, ams_pkg::OP_STOREX: begin
          fl_set = (adr == '0);
        end
        ams_pkg::OP_POP: begin
          fl_set = (adr == '0);
          sp_n   = sp_q - WORD_BITS'(1);
        end
        ams_pkg::OP_CMP: begin
          fl_set = 1'b1;
          cmp_b  = opnd_q;
        end
        ams_pkg::OP_JMP, ams_pkg::OP_CALL: pc_n = 32'(adr);
        ams_pkg::OP_JGT: if (flags_q[2]) pc_n = 32'(adr);
        ams_pkg::OP_JEQ: if (flags_q[1]) pc_n = 32'(adr);
        ams_pkg::OP_JLT: if (flags_q[0]) pc_n = 32'(adr);
        ams_pkg::OP_JNE: if (!flags_q[1]) pc_n = 32'(adr);
        ams_pkg::OP_HALT, ams_pkg::OP_LOADX: x_n = opnd_q;
        ams_pkg::OP_READCH: begin
          acc_n  = rc_val;
          fl_set = 1'b1;
        end
        ams_pkg::OP_RET: begin
          pc_n = 32'(opnd_q);
          sp_n = sp_q - WORD_BITS'(1);
        end
        ams_pkg::OP_JMPI, ams_pkg::OP_CALLI: pc_n = 32'(opnd_q);
        ams_pkg::OP_JGTI: if (flags_q[2]) pc_n = 32'(opnd_q);
        ams_pkg::OP_JEQI: if (flags_q[1]) pc_n = 32'(opnd_q);
        ams_pkg::OP_JLTI: if (flags_q[0]) pc_n = 32'(opnd_q);
        ams_pkg::OP_JNEI: if (!flags_q[1]) pc_n = 32'(opnd_q);
        ams_pkg::OP_LOADV: begin
          acc_n  = (32'(adr) > 32'(ams_pkg::LOADV_LIMIT)) ? WORD_BITS'($signed(adr))
                                                         : WORD_BITS'(adr);
          fl_set = 1'b1;
        end
        ams_pkg::OP_MUL: begin
          acc_n  = md_res;
          fl_set = 1'b1;
        end
        ams_pkg::OP_DIV, ams_pkg::OP_MOD: begin
          if (!div_zero) begin
            acc_n  = md_res;
            fl_set = 1'b1;
          end
        end
        ams_pkg::OP_NOT: begin
          acc_n  = ~acc_q;
          fl_set = 1'b1;
        end
        ams_pkg::OP_AND: begin
          acc_n  = acc_q & opnd_q;
          fl_set = 1'b1;
        end
        ams_pkg::OP_OR: begin
          acc_n  = acc_q | opnd_q;
          fl_set = 1'b1;
        end
        default: begin
          acc_n = acc_q;
        end
      endcase
    end
    flags_n = fl_set ? {($signed(acc_n) > $signed(cmp_b)), (acc_n == cmp_b),
                        ($signed(acc_n) < $signed(cmp_b))} : flags_q;
  end

  // result item
  always_comb begin
    res              = '0;
    res.status       = ams_pkg::STAT_OK;
    res.output_kind  = ams_pkg::OUT_NONE;
    res.pc_now       = pc_n;
    res.acc_now      = 32'($signed(acc_n));
    res.flags_now    = flags_n;
    if (item_q.opcode == ams_pkg::ITEM_EXEC) begin
      if (op_valid && op == ams_pkg::OP_WRITEINT) begin
        res.output_kind  = ams_pkg::OUT_INT;
        res.output_value = 32'($signed(opnd_q));
      end else if (op_valid && op == ams_pkg::OP_WRITECH) begin
        res.output_kind = ams_pkg::OUT_CHAR;
        if (acc_q == WORD_BITS'(ams_pkg::CODE_LF) || acc_q == WORD_BITS'(ams_pkg::CODE_CR)) begin
          res.output_value = 32'(ams_pkg::CODE_LF);
        end else begin
          res.output_value = {24'd0, acc_q[7:0]};
        end
      end
      res.used_input = op_valid && (op == ams_pkg::OP_READINT || op == ams_pkg::OP_READCH);
      if (op_valid && op == ams_pkg::OP_READCH && rc_val == WORD_BITS'(ams_pkg::CODE_ESC)) begin
        res.status = ams_pkg::STAT_ESCAPE;
      end else if (abort_q || (op_valid && div_zero)) begin
        res.status = ams_pkg::STAT_ABORT;
      end else if (!op_valid) begin
        res.status = ams_pkg::STAT_INVALID;
      end else if (op == ams_pkg::OP_HALT) begin
        res.status = ams_pkg::STAT_HALT;
      end else if (pc_n == {20'd0, bp_q}) begin
        res.status = ams_pkg::STAT_BREAK;
      end
    end
  end

  // machine registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      x_q     <= '0;
      sp_q    <= SpReset;
      mark_q  <= '0;
      pc_q    <= ams_pkg::PC_RESET;
      flags_q <= '0;
      abort_q <= 1'b0;
    end else begin
      if (cmd_i.misc) begin
        case (item_q.opcode)
          ams_pkg::ITEM_LOAD: begin
            if (load_in && load_reg) begin
              case (item_q.address[1:0])
                2'd0:    acc_q <= ld_word;
                2'd1:    x_q   <= ld_word;
                default: sp_q  <= ld_word;
              endcase
              mark_q[item_q.address[1:0]] <= item_q.mark_instruction;
            end
          end
          ams_pkg::ITEM_REGS: begin
            pc_q  <= ams_pkg::PC_RESET;
            acc_q <= '0;
            x_q   <= '0;
            sp_q  <= SpReset;
          end
          ams_pkg::ITEM_CLEAR: begin
            acc_q  <= FillWord;
            x_q    <= FillWord;
            sp_q   <= FillWord;
            mark_q <= '0;
          end
          default: begin
            abort_q <= 1'b0;
          end
        endcase
      end
      if (cmd_i.decode) begin
        pc_q    <= pc_q + 32'd1;
        abort_q <= rd_oor_q;
      end
      if (cmd_i.pre) begin
        sp_q <= sp_q + WORD_BITS'(1);
      end
      if (cmd_i.rd_wait && rd_oor_q) begin
        abort_q <= 1'b1;
      end
      if (cmd_i.wr_do) begin
        if (!wr_ok) begin
          abort_q <= 1'b1;
        end else if (rd_hit_q) begin
          case (rd_idx_q)
            2'd0:    acc_q <= wr_data;
            2'd1:    x_q   <= wr_data;
            default: sp_q  <= wr_data;
          endcase
        end
      end
      if (cmd_i.exec) begin
        acc_q   <= acc_n;
        x_q     <= x_n;
        sp_q    <= sp_n;
        pc_q    <= pc_n;
        flags_q <= flags_n;
      end
    end
  end

  // item, instruction and operand holding
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.decode) begin
      instr_q <= rd_val;
    end
    if (cmd_i.rd_wait) begin
      opnd_q <= rd_val;
    end
    if (cmd_i.exec) begin
      out_q <= res;
    end
  end

  // breakpoint register and clearing sweep counter
  assign clr_last = clr_cnt_q == AW'(MEMORY_WORDS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q      <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        bp_q <= cfg_data_i;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_last ? '0 : clr_cnt_q + AW'(1);
      end
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status towards the controller
  always_comb begin
    stat_o           = '0;
    stat_o.item_kind = item_q.opcode;
    stat_o.op_valid  = op_valid;
    stat_o.info      = ams_pkg::ams_op_info(op);
    stat_o.md_done   = md_done;
    stat_o.clr_last  = clr_last;
    stat_o.out_free  = out_free;
  end

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> out_valid_q)
    else $error("result lost at commit");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(flags_q))
    else $error("more than one condition flag set");

endmodule

// ----- rtl/core/ams_ctrl.sv -----
// Controller state machine of the accumulator machine
// Depends on ams_pkg for state, command and status types
module ams_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ams_pkg::ams_stat_t stat_i,
  output ams_pkg::ams_cmd_t  cmd_o
);

  ams_pkg::ams_state_e state_q, state_d, first_ph;
  logic                report_q, report_d;

  // first phase after the decode
  always_comb begin
    if (stat_i.info.wr_first) begin
      first_ph = ams_pkg::ST_WR_CHK;
    end else if (stat_i.info.rd) begin
      first_ph = ams_pkg::ST_RD;
    end else if (stat_i.info.md) begin
      first_ph = ams_pkg::ST_MD_GO;
    end else if (stat_i.info.wr) begin
      first_ph = ams_pkg::ST_WR_CHK;
    end else begin
      first_ph = ams_pkg::ST_EXEC;
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    report_d = report_q;
    case (state_q)
      ams_pkg::ST_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d  = report_q ? ams_pkg::ST_EXEC : ams_pkg::ST_IDLE;
          report_d = 1'b0;
        end
      end
      ams_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ams_pkg::ST_MISC;
      end
      ams_pkg::ST_MISC: begin
        case (stat_i.item_kind)
          ams_pkg::ITEM_EXEC: state_d = ams_pkg::ST_FETCH;
          ams_pkg::ITEM_CLEAR: begin
            state_d  = ams_pkg::ST_CLEAR;
            report_d = 1'b1;
          end
          default: state_d = ams_pkg::ST_EXEC;
        endcase
      end
      ams_pkg::ST_FETCH: state_d = ams_pkg::ST_DECODE;
      ams_pkg::ST_DECODE: begin
        if (!stat_i.op_valid) begin
          state_d = ams_pkg::ST_EXEC;
        end else if (stat_i.info.pre) begin
          state_d = ams_pkg::ST_PRE;
        end else begin
          state_d = first_ph;
        end
      end
      ams_pkg::ST_PRE:    state_d = first_ph;
      ams_pkg::ST_WR_CHK: state_d = ams_pkg::ST_WR_DO;
      ams_pkg::ST_WR_DO: begin
        state_d = stat_i.info.wr_first ? ams_pkg::ST_RD : ams_pkg::ST_EXEC;
      end
      ams_pkg::ST_RD: state_d = ams_pkg::ST_RD_WAIT;
      ams_pkg::ST_RD_WAIT: begin
        if (stat_i.info.wr_first) begin
          state_d = ams_pkg::ST_EXEC;
        end else if (stat_i.info.md) begin
          state_d = ams_pkg::ST_MD_GO;
        end else if (stat_i.info.wr) begin
          state_d = ams_pkg::ST_WR_CHK;
        end else begin
          state_d = ams_pkg::ST_EXEC;
        end
      end
      ams_pkg::ST_MD_GO: state_d = ams_pkg::ST_MD;
      ams_pkg::ST_MD: begin
        if (stat_i.md_done) state_d = ams_pkg::ST_EXEC;
      end
      ams_pkg::ST_EXEC: begin
        if (stat_i.out_free) state_d = ams_pkg::ST_IDLE;
      end
      default: state_d = ams_pkg::ST_IDLE;
    endcase
  end

  // state register, the clearing pass runs first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ams_pkg::ST_CLEAR;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      report_q <= report_d;
    end
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == ams_pkg::ST_IDLE) && in_valid_i;
    cmd_o.misc     = (state_q == ams_pkg::ST_MISC);
    cmd_o.clr_step = (state_q == ams_pkg::ST_CLEAR);
    cmd_o.fetch    = (state_q == ams_pkg::ST_FETCH);
    cmd_o.decode   = (state_q == ams_pkg::ST_DECODE);
    cmd_o.pre      = (state_q == ams_pkg::ST_PRE);
    cmd_o.wr_chk   = (state_q == ams_pkg::ST_WR_CHK);
    cmd_o.wr_do    = (state_q == ams_pkg::ST_WR_DO);
    cmd_o.rd       = (state_q == ams_pkg::ST_RD);
    cmd_o.rd_wait  = (state_q == ams_pkg::ST_RD_WAIT);
    cmd_o.md_start = (state_q == ams_pkg::ST_MD_GO);
    cmd_o.exec     = (state_q == ams_pkg::ST_EXEC) && stat_i.out_free;
  end

  assign in_ready_o = (state_q == ams_pkg::ST_IDLE);

  a_md_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ams_pkg::ST_MD && stat_i.md_done) |=> state_q == ams_pkg::ST_EXEC)
    else $error("muldiv completion missed");

  a_accept_misc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ams_pkg::ST_MISC)
    else $error("accepted item not dispatched");

endmodule

// ----- rtl/core/accumulator_machine_step.sv -----
// Top level of the accumulator machine step block
// Depends on ams_pkg, ams_ctrl and ams_dp
//
// Each input transfer carries one item: execute one instruction, load a memory word, reset
// the registers, or clear memory; each item gives exactly one result transfer. One item is
// worked on at a time, and the next is taken while a result still waits in the output
// register. An execute item steps through fetch, decode, an optional stack pre-increment,
// its memory reads and checked stores, and for multiply, divide and modulo the one bit per
// cycle multiply/divide unit, paced by the word memory with its registered read. Load and
// register reset items pass through the dispatch state to the commit; a clear memory item
// walks the memory one word a cycle. After reset the same clearing pass runs before the
// first item is taken; breakpoint writes are taken at any time.
module accumulator_machine_step #(
  parameter int MEMORY_WORDS = 4096,
  parameter int WORD_BITS    = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ams_pkg::ams_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ams_pkg::ams_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [11:0]       cfg_data_i
);

  ams_pkg::ams_cmd_t  cmd;
  ams_pkg::ams_stat_t stat;

  // breakpoint writes always complete
  assign cfg_ready_o = 1'b1;

  // sequencer
  ams_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // memory, registers and arithmetic
  ams_dp #(
    .MEMORY_WORDS (MEMORY_WORDS),
    .WORD_BITS    (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the accumulator machine step block
// Depends on ams_pkg and accumulator_machine_step; runs directed programs then random ones
// A behavioural machine model predicts each result, which is checked field by field
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_WORDS   = 4096;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DATA_BASE   = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  ams_pkg::ams_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  ams_pkg::ams_out_t out_data_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [11:0]       cfg_data_i;

  accumulator_machine_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // machine state mirrored by the predictor
  logic [31:0] mem_words [MEM_WORDS];
  bit          mem_marks [MEM_WORDS];
  logic [31:0] prog_ctr;
  bit          flag_lt, flag_eq, flag_gt;
  logic [11:0] break_addr;
  bit          mem_fault;

  ams_pkg::ams_out_t pending_results [$];
  int          mismatch_count;
  int          cycle_count;
  int          stall_pct;
  int          burst_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] mem_read(input longint a);
    if (a < 0 || a >= MEM_WORDS) begin
      mem_fault = 1'b1;
      return 32'd0;
    end
    return mem_words[a];
  endfunction

  function automatic void mem_write(input longint a, input logic [31:0] v);
    if (a < 0 || a >= MEM_WORDS || mem_marks[a]) begin
      mem_fault = 1'b1;
      return;
    end
    mem_words[a] = v;
  endfunction

  function automatic void set_cmp_flags(input logic [31:0] v);
    flag_lt = $signed(mem_words[0]) < $signed(v);
    flag_eq = $signed(mem_words[0]) == $signed(v);
    flag_gt = $signed(mem_words[0]) > $signed(v);
  endfunction

  function automatic void fill_memory();
    for (int i = 0; i < MEM_WORDS; i++) begin
      mem_words[i] = 32'(ams_pkg::FILL_VALUE);
      mem_marks[i] = 1'b0;
    end
  endfunction

  function automatic void reset_regs();
    prog_ctr     = ams_pkg::PC_RESET;
    mem_words[0] = '0;
    mem_words[1] = '0;
    mem_words[2] = 32'(ams_pkg::STACK_RESET);
  endfunction

  function automatic longint sp_addr();
    return longint'($signed(mem_words[2]));
  endfunction

  // signed divide truncating toward zero, done on magnitudes
  function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d,
                                            input bit want_rem);
    logic [31:0] mn, md, q, r;
    mn = n[31] ? -n : n;
    md = d[31] ? -d : d;
    q  = mn / md;
    r  = mn % md;
    if (want_rem) return n[31] ? -r : r;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  // works out the result of one item and updates the mirrored machine
  function automatic ams_pkg::ams_out_t machine_step(input ams_pkg::ams_in_t it);
    ams_pkg::ams_out_t r;
    logic [31:0] w, v, ival;
    logic [20:0] op;
    logic [10:0] adr;
    bit          bad_op, halted, escaped;
    r = '0;
    bad_op = 0; halted = 0; escaped = 0;
    ival = it.input_value;
    case (it.opcode)
      ams_pkg::ITEM_LOAD: begin
        mem_words[it.address] = it.data_word;
        mem_marks[it.address] = it.mark_instruction;
      end
      ams_pkg::ITEM_REGS:  reset_regs();
      ams_pkg::ITEM_CLEAR: fill_memory();
      default: begin
        mem_fault = 1'b0;
        w   = mem_read(longint'($signed(prog_ctr)));
        adr = w[10:0];
        op  = w[31:11];
        prog_ctr = prog_ctr + 32'd1;
        case (op)
          ams_pkg::OP_LOAD: begin
            mem_words[0] = mem_read(adr); set_cmp_flags(32'd0);
          end
          ams_pkg::OP_STORE: begin
            mem_write(adr, mem_words[0]); if (adr == 11'd0) set_cmp_flags(32'd0);
          end
          ams_pkg::OP_CLEAR: begin mem_words[0] = '0; set_cmp_flags(32'd0); end
          ams_pkg::OP_ADD: begin
            mem_words[0] = mem_words[0] + mem_read(adr); set_cmp_flags(32'd0);
          end
          ams_pkg::OP_INC:   mem_write(adr, mem_read(adr) + 32'd1);
          ams_pkg::OP_SUB: begin
            mem_words[0] = mem_words[0] - mem_read(adr); set_cmp_flags(32'd0);
          end
          ams_pkg::OP_DEC:   mem_write(adr, mem_read(adr) - 32'd1);
          ams_pkg::OP_CMP:   set_cmp_flags(mem_read(adr));
          ams_pkg::OP_JMP:   prog_ctr = 32'(adr);
          ams_pkg::OP_JGT:   if (flag_gt) prog_ctr = 32'(adr);
          ams_pkg::OP_JEQ:   if (flag_eq) prog_ctr = 32'(adr);
          ams_pkg::OP_JLT:   if (flag_lt) prog_ctr = 32'(adr);
          ams_pkg::OP_JNE:   if (!flag_eq) prog_ctr = 32'(adr);
          ams_pkg::OP_READINT: begin r.used_input = 1'b1; mem_write(adr, ival); end
          ams_pkg::OP_WRITEINT: begin
            r.output_kind = ams_pkg::OUT_INT; r.output_value = mem_read(adr);
          end
          ams_pkg::OP_HALT:  begin halted = 1; mem_words[1] = mem_read(adr); end
          ams_pkg::OP_LOADX: mem_words[1] = mem_read(adr);
          ams_pkg::OP_STOREX: begin
            mem_write(adr, mem_words[1]); if (adr == 11'd0) set_cmp_flags(32'd0);
          end
          ams_pkg::OP_LOADIX: begin
            v = 32'(adr) + mem_words[1];
            mem_words[0] = mem_read(longint'($signed(v)));
            set_cmp_flags(32'd0);
          end
          ams_pkg::OP_STOREIX: begin
            v = 32'(adr) + mem_words[1];
            mem_write(longint'($signed(v)), mem_words[0]);
          end
          ams_pkg::OP_READCH: begin
            r.used_input = 1'b1;
            mem_words[0] = (ival == 32'(ams_pkg::CODE_LF)) ? 32'(ams_pkg::CODE_CR) : ival;
            set_cmp_flags(32'd0);
            if (mem_words[0] == 32'(ams_pkg::CODE_ESC)) escaped = 1;
          end
          ams_pkg::OP_WRITECH: begin
            r.output_kind  = ams_pkg::OUT_CHAR;
            r.output_value = (mem_words[0] == 32'(ams_pkg::CODE_LF) ||
                              mem_words[0] == 32'(ams_pkg::CODE_CR)) ?
                             32'(ams_pkg::CODE_LF) : {24'd0, mem_words[0][7:0]};
          end
          ams_pkg::OP_CALL: begin
            mem_words[2] = mem_words[2] + 32'd1;
            mem_write(sp_addr(), prog_ctr);
            prog_ctr = 32'(adr);
          end
          ams_pkg::OP_RET: begin
            prog_ctr = mem_read(sp_addr());
            mem_words[2] = mem_words[2] - 32'd1;
          end
          ams_pkg::OP_PUSH: begin
            mem_words[2] = mem_words[2] + 32'd1;
            v = mem_read(adr);
            mem_write(sp_addr(), v);
          end
          ams_pkg::OP_POP: begin
            mem_write(adr, mem_read(sp_addr()));
            mem_words[2] = mem_words[2] - 32'd1;
            if (adr == 11'd0) set_cmp_flags(32'd0);
          end
          ams_pkg::OP_JMPI:  prog_ctr = mem_read(adr);
          ams_pkg::OP_JGTI:  if (flag_gt) prog_ctr = mem_read(adr);
          ams_pkg::OP_JEQI:  if (flag_eq) prog_ctr = mem_read(adr);
          ams_pkg::OP_JLTI:  if (flag_lt) prog_ctr = mem_read(adr);
          ams_pkg::OP_JNEI:  if (!flag_eq) prog_ctr = mem_read(adr);
          ams_pkg::OP_LOADV: begin
            mem_words[0] = (32'(adr) > 32'(ams_pkg::LOADV_LIMIT)) ? {{21{1'b1}}, adr}
                                                                  : 32'(adr);
            set_cmp_flags(32'd0);
          end
          ams_pkg::OP_MUL: begin
            mem_words[0] = mem_words[0] * mem_read(adr); set_cmp_flags(32'd0);
          end
          ams_pkg::OP_DIV, ams_pkg::OP_MOD: begin
            v = mem_read(adr);
            if (v == 32'd0) mem_fault = 1'b1;
            else begin
              mem_words[0] = div_trunc(mem_words[0], v, op == 21'(ams_pkg::OP_MOD));
              set_cmp_flags(32'd0);
            end
          end
          ams_pkg::OP_NOT: begin mem_words[0] = ~mem_words[0]; set_cmp_flags(32'd0); end
          ams_pkg::OP_AND: begin
            mem_words[0] = mem_words[0] & mem_read(adr); set_cmp_flags(32'd0);
          end
          ams_pkg::OP_OR: begin
            mem_words[0] = mem_words[0] | mem_read(adr); set_cmp_flags(32'd0);
          end
          ams_pkg::OP_CALLI: begin
            mem_words[2] = mem_words[2] + 32'd1;
            mem_write(sp_addr(), prog_ctr);
            prog_ctr = mem_read(adr);
          end
          default: bad_op = 1;
        endcase
        if (escaped) r.status = ams_pkg::STAT_ESCAPE;
        else if (mem_fault) r.status = ams_pkg::STAT_ABORT;
        else if (bad_op) r.status = ams_pkg::STAT_INVALID;
        else if (halted) r.status = ams_pkg::STAT_HALT;
        else if (prog_ctr == 32'(break_addr)) r.status = ams_pkg::STAT_BREAK;
      end
    endcase
    r.pc_now    = prog_ctr;
    r.acc_now   = mem_words[0];
    r.flags_now = {flag_gt, flag_eq, flag_lt};
    return r;
  endfunction

  // send one item, predict its result on transfer
  task automatic send_item(input ams_pkg::ams_in_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(machine_step(it));
    // bursts with random gaps between them
    if (burst_left > 0) burst_left--;
    else begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  function automatic ams_pkg::ams_in_t make_item(input logic [1:0] kind, input logic [11:0] a,
                                                 input logic [31:0] d, input bit mark,
                                                 input logic [31:0] ival);
    ams_pkg::ams_in_t it;
    it.opcode = kind;
    it.address = a;
    it.data_word = d;
    it.mark_instruction = mark;
    it.input_value = ival;
    return it;
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic load_word(input logic [11:0] a, input logic [31:0] d, input bit mark);
    send_item(make_item(ams_pkg::ITEM_LOAD, a, d, mark, $urandom));
  endtask

  task automatic exec_item(input logic [31:0] ival);
    send_item(make_item(ams_pkg::ITEM_EXEC, 12'($urandom), $urandom, rand_bit(), ival));
  endtask

  // place an instruction at the program counter and run it
  task automatic run_instr(input logic [31:0] word, input logic [31:0] ival);
    longint here;
    here = longint'($signed(prog_ctr));
    if (here < 0 || here >= MEM_WORDS) begin
      send_item(make_item(ams_pkg::ITEM_REGS, 12'($urandom), $urandom, rand_bit(),
                          $urandom));
      here = longint'($signed(prog_ctr));
    end
    load_word(here[11:0], word, $urandom_range(0, 3) == 0);
    exec_item(ival);
  endtask

  function automatic logic [31:0] instr(input logic [5:0] op, input logic [10:0] a);
    return {15'd0, op, a};
  endfunction

  // sender holds off until every expected result has come
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_breakpoint(input logic [11:0] v);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    break_addr = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // every instruction once, over a table of extreme data words
  task automatic test_all_opcodes();
    load_word(12'(DATA_BASE + 0), 32'h7fff_ffff, 0);
    load_word(12'(DATA_BASE + 1), 32'h8000_0000, 0);
    load_word(12'(DATA_BASE + 2), 32'hffff_ffff, 0);
    load_word(12'(DATA_BASE + 3), 32'd0, 0);
    load_word(12'(DATA_BASE + 4), 32'd7, 0);
    for (int op = 0; op < ams_pkg::OPCODE_COUNT; op++)
      run_instr(instr(op[5:0], 11'(DATA_BASE + (op % 5))), $urandom);
  endtask

  // special cases: invalid words, faults, console codes, divide corners
  task automatic test_special_cases();
    run_instr(instr(6'd39, 11'd0), 32'd0);
    run_instr(32'hffff_ffff, 32'd0);
    run_instr(instr(ams_pkg::OP_DIV, 11'(DATA_BASE + 3)), 32'd0);
    run_instr(instr(ams_pkg::OP_LOAD, 11'(DATA_BASE + 1)), 32'd0);
    run_instr(instr(ams_pkg::OP_DIV, 11'(DATA_BASE + 2)), 32'd0);
    run_instr(instr(ams_pkg::OP_READCH, 11'd0), 32'(ams_pkg::CODE_LF));
    run_instr(instr(ams_pkg::OP_WRITECH, 11'd0), 32'd0);
    run_instr(instr(ams_pkg::OP_READCH, 11'd0), 32'(ams_pkg::CODE_ESC));
    load_word(12'(DATA_BASE + 5), 32'd1, 1);
    run_instr(instr(ams_pkg::OP_STORE, 11'(DATA_BASE + 5)), 32'd0);
    load_word(12'(DATA_BASE + 6), 32'd5000, 0);
    run_instr(instr(ams_pkg::OP_JMPI, 11'(DATA_BASE + 6)), 32'd0);
    exec_item(32'd0);
    load_word(12'(DATA_BASE + 6), 32'hffff_fffb, 0);
    run_instr(instr(ams_pkg::OP_JMPI, 11'(DATA_BASE + 6)), 32'd0);
    exec_item(32'd0);
    run_instr(instr(ams_pkg::OP_LOADV, 11'h7ff), 32'd0);
    run_instr(instr(ams_pkg::OP_HALT, 11'(DATA_BASE + 4)), 32'd0);
  endtask

  // breakpoint at both extremes and in between
  task automatic test_breakpoint();
    write_breakpoint(12'd4095);
    run_instr(instr(ams_pkg::OP_JMP, 11'd2047), 32'd0);
    write_breakpoint(12'd0);
    run_instr(instr(ams_pkg::OP_JMP, 11'd0), 32'd0);
    write_breakpoint(12'd40);
    run_instr(instr(ams_pkg::OP_JMP, 11'd40), 32'd0);
    run_instr(instr(ams_pkg::OP_JMP, 11'd39), 32'd0);
    exec_item(32'd0);
  endtask

  function automatic logic [10:0] pick_addr();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 11'($urandom_range(0, 2));
    if (sel < 60) return 11'($urandom_range(3, 63));
    if (sel < 75) return 11'($urandom_range(1990, 2047));
    return 11'($urandom);
  endfunction

  function automatic logic [31:0] pick_input();
    case ($urandom_range(0, 7))
      0: return 32'(ams_pkg::CODE_LF);
      1: return 32'(ams_pkg::CODE_CR);
      2: return 32'(ams_pkg::CODE_ESC);
      3: return 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed programs with random content, some noise
  task automatic test_random_programs();
    int sel;
    logic [31:0] word;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 999);
      if (n % 400 == 399) drain_results();
      if (n % 700 == 350) write_breakpoint(12'($urandom));
      if (sel < 650) begin
        word = ($urandom_range(0, 19) == 0) ? $urandom :
               instr(6'($urandom_range(0, 41)), pick_addr());
        run_instr(word, pick_input());
      end else if (sel < 850) begin
        load_word(($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'(pick_addr()),
                  ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 100) - 50),
                  $urandom_range(0, 7) == 0);
      end else if (sel < 930) begin
        exec_item(pick_input());
      end else if (sel < 960) begin
        send_item(make_item(ams_pkg::ITEM_REGS, 12'($urandom), $urandom, rand_bit(),
                            $urandom));
      end else if (sel < 965) begin
        send_item(make_item(ams_pkg::ITEM_CLEAR, 12'($urandom), $urandom, rand_bit(),
                            $urandom));
      end else begin
        send_item(make_item(2'($urandom), 12'($urandom), $urandom, rand_bit(), $urandom));
      end
    end
  endtask

  // receiver stall pattern, with a stall percentage drawn anew from a fixed set
  always @(negedge clk_i) begin
    if (cycle_count % 512 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 20;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    ams_pkg::ams_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: %p", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status || out_data_o.output_kind !== want.output_kind
            || out_data_o.output_value !== want.output_value
            || out_data_o.used_input !== want.used_input
            || out_data_o.pc_now !== want.pc_now || out_data_o.acc_now !== want.acc_now
            || out_data_o.flags_now !== want.flags_now) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p actual %p", want, out_data_o);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    out_ready_i = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    stall_pct = 0;
    burst_left = 0;
    break_addr = '0;
    flag_lt = 0; flag_eq = 0; flag_gt = 0;
    fill_memory();
    reset_regs();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_all_opcodes();
    test_special_cases();
    test_breakpoint();
    test_random_programs();

    drain_results();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ams_pkg.sv
rtl/core/ams_muldiv.sv
rtl/core/ams_dp.sv
rtl/core/ams_ctrl.sv
rtl/core/accumulator_machine_step.sv
tb/testbench.sv
